### hw/rtl/tmw_pkg.sv
package tmw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  // Port widths fixed by the interface.
  localparam int CHAR_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int VALUE_W    = 16;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Character codes with a control meaning, and the space used for blank cells.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Color register reset values.
  localparam logic [2:0] FORE_COLOR_RST  = 3'd7;
  localparam logic       FORE_BRIGHT_RST = 1'b0;
  localparam logic [2:0] BACK_COLOR_RST  = 3'd0;
  localparam logic       BACK_BRIGHT_RST = 1'b0;

  // Blank cell in the reset colors, used by the clearing pass.
  localparam logic [VALUE_W-1:0] RESET_BLANK =
    {BACK_BRIGHT_RST, BACK_COLOR_RST, FORE_BRIGHT_RST, FORE_COLOR_RST, CH_SPACE};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORE_COLOR  = 2'd0,
    CFG_FORE_BRIGHT = 2'd1,
    CFG_BACK_COLOR  = 2'd2,
    CFG_BACK_BRIGHT = 2'd3
  } cfg_reg_t;

  // Status of one cursor step.
  typedef struct packed {
    logic written;
    logic scroll;
  } step_flags_t;

endpackage

### hw/rtl/text_mode_terminal_writer.sv
// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_stall   | in_char_code
// result   | out       | out_valid / out_stall | out_cell_written, out_cell_index,
//          |           |                       | out_cell_value, out_scrolled, out_cursor_*
// config   | in        | cfg_we                | cfg_index, cfg_wdata
//
// A control code or a plain character is accepted in S_IDLE; in S_CALC the
// cursor step is computed and the cell is written.
// A scroll then copies rows 1 to ROWS-1 up by one row and fills the bottom
// row with blanks on the single cell memory port; S_DONE hands off the result item.
// After reset a clearing pass writes every cell with in_stall high; configuration
// writes are taken during it.
// A stalled result item waits in the output register while the next item is taken.
module text_mode_terminal_writer #(
  parameter int COLUMNS  = tmw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tmw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tmw_pkg::TAB_STOP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tmw_pkg::CHAR_W-1:0]      in_char_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_cell_written,
  output logic [tmw_pkg::INDEX_W-1:0]     out_cell_index,
  output logic [tmw_pkg::VALUE_W-1:0]     out_cell_value,
  output logic                            out_scrolled,
  output logic [tmw_pkg::COL_W-1:0]       out_cursor_col,
  output logic [tmw_pkg::ROW_W-1:0]       out_cursor_row,
  output logic [tmw_pkg::INDEX_W-1:0]     out_cursor_offset,
  input  logic                            cfg_we,
  input  logic [tmw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tmw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tmw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_CALC   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Color registers.
  logic [2:0] fore_color_r;
  logic       fore_bright_r;
  logic [2:0] back_color_r;
  logic       back_bright_r;
  logic [7:0] attr;
  logic [VALUE_W-1:0] blank;

  // Cursor and the item being worked on.
  logic [CW-1:0]     cur_col_r;
  logic [RW-1:0]     cur_row_r;
  logic [CHAR_W-1:0] ch_r;

  // Cursor step results.
  logic [CW-1:0]     step_col;
  logic [RW-1:0]     step_row;
  logic [AW-1:0]     step_idx;
  logic [AW-1:0]     step_off;
  step_flags_t       step_flags;
  logic [VALUE_W-1:0] step_val;

  // Result item held while a scroll runs or the output register is busy.
  logic               res_written_r;
  logic [AW-1:0]      res_idx_r;
  logic [VALUE_W-1:0] res_val_r;
  logic               res_scrolled_r;
  logic [CW-1:0]      res_col_r;
  logic [RW-1:0]      res_row_r;
  logic [AW-1:0]      res_off_r;

  // Output register.
  logic out_valid_r;
  logic out_free;
  logic load_calc;
  logic load_res;

  // Cell store and its sweep machinery. One address counter walks the store
  // for the clearing pass, the row copy of a scroll and the blank fill.
  logic [VALUE_W-1:0] mem [CELLS];
  logic [VALUE_W-1:0] rd_data_r;
  logic [AW-1:0]      sweep_r;
  logic               cp_v_r;
  logic [AW-1:0]      cp_wa_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [AW-1:0]      mem_ra;
  logic [VALUE_W-1:0] mem_wd;

  assign attr  = {back_bright_r, back_color_r, fore_bright_r, fore_color_r};
  assign blank = {attr, CH_SPACE};

  // Configuration writes are taken in every state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_color_r  <= FORE_COLOR_RST;
      fore_bright_r <= FORE_BRIGHT_RST;
      back_color_r  <= BACK_COLOR_RST;
      back_bright_r <= BACK_BRIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORE_COLOR:  fore_color_r  <= cfg_wdata[2:0];
        CFG_FORE_BRIGHT: fore_bright_r <= cfg_wdata[0];
        CFG_BACK_COLOR:  back_color_r  <= cfg_wdata[2:0];
        CFG_BACK_BRIGHT: back_bright_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tmw_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_cursor (
    .ch      (ch_r),
    .col_i   (cur_col_r),
    .row_i   (cur_row_r),
    .col_o   (step_col),
    .row_o   (step_row),
    .idx_o   (step_idx),
    .off_o   (step_off),
    .flags_o (step_flags)
  );

  // A backspace writes a blank; any other written cell carries the character.
  assign step_val = (ch_r == CH_BS) ? blank : {attr, ch_r};

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer and memory port selection.
  always_comb begin
    state_nxt = state_r;
    load_calc = 1'b0;
    load_res  = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = sweep_r;
    mem_wd    = blank;
    mem_ra    = sweep_r;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = RESET_BLANK;
        if (sweep_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        mem_we = step_flags.written;
        mem_wa = step_idx;
        mem_wd = step_val;
        if (step_flags.scroll) begin
          state_nxt = S_SCROLL;
        end else if (out_free) begin
          load_calc = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCROLL: begin
        // Read one row below, write the word read in the previous cycle.
        mem_ra = sweep_r + AW'(COLUMNS);
        mem_we = cp_v_r;
        mem_wa = cp_wa_r;
        mem_wd = rd_data_r;
        if (sweep_r == AW'(COPY_N - 1)) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        // The first cycle finishes the last copy write before the fill starts.
        mem_we = 1'b1;
        if (cp_v_r) begin
          mem_wa = cp_wa_r;
          mem_wd = rd_data_r;
        end else if (sweep_r == AW'(CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_res  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      sweep_r   <= '0;
      cp_v_r    <= 1'b0;
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      state_r <= state_nxt;
      cp_v_r  <= (state_r == S_SCROLL);
      case (state_r)
        S_CLEAR: begin
          sweep_r <= (sweep_r == AW'(CELLS - 1)) ? '0 : sweep_r + AW'(1);
        end
        S_CALC: begin
          sweep_r   <= '0;
          cur_col_r <= step_col;
          cur_row_r <= step_row;
        end
        S_SCROLL: begin
          sweep_r <= sweep_r + AW'(1);
        end
        S_FILL: begin
          if (!cp_v_r) begin
            sweep_r <= (sweep_r == AW'(CELLS - 1)) ? '0 : sweep_r + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cp_wa_r <= sweep_r;
    if (state_r == S_IDLE && in_valid) begin
      ch_r <= in_char_code;
    end
    if (state_r == S_CALC) begin
      res_written_r  <= step_flags.written;
      res_idx_r      <= step_idx;
      res_val_r      <= step_flags.written ? step_val : '0;
      res_scrolled_r <= step_flags.scroll;
      res_col_r      <= step_col;
      res_row_r      <= step_row;
      res_off_r      <= step_off;
    end
  end

  // Cell store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_calc || load_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_calc) begin
      out_cell_written  <= step_flags.written;
      out_cell_index    <= INDEX_W'(step_idx);
      out_cell_value    <= step_flags.written ? step_val : '0;
      out_scrolled      <= step_flags.scroll;
      out_cursor_col    <= COL_W'(step_col);
      out_cursor_row    <= ROW_W'(step_row);
      out_cursor_offset <= INDEX_W'(step_off);
    end else if (load_res) begin
      out_cell_written  <= res_written_r;
      out_cell_index    <= INDEX_W'(res_idx_r);
      out_cell_value    <= res_val_r;
      out_scrolled      <= res_scrolled_r;
      out_cursor_col    <= COL_W'(res_col_r);
      out_cursor_row    <= ROW_W'(res_row_r);
      out_cursor_offset <= INDEX_W'(res_off_r);
    end
  end

  assign out_valid = out_valid_r;

  // The cursor always stays on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS))
    else $error("cursor left the screen");

  // A copy write only follows a read issued during the scroll.
  a_copy_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cp_v_r |-> $past(state_r) == S_SCROLL)
    else $error("copy write without a scroll read");

  // The store is never written while waiting for an item.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("cell store written while idle");

  // A scroll always ends with the cursor on the bottom row.
  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (int'(cur_row_r) == ROWS - 1))
    else $error("scroll with cursor off the bottom row");

  // A result item is never overwritten while it is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load_calc || load_res) |-> out_free)
    else $error("result item overwritten while stalled");

endmodule

### hw/rtl/tmw_cursor.sv
module tmw_cursor #(
  parameter int COLUMNS  = tmw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tmw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tmw_pkg::TAB_STOP_DEF
) (
  input  logic [tmw_pkg::CHAR_W-1:0]     ch,
  input  logic [$clog2(COLUMNS)-1:0]     col_i,
  input  logic [$clog2(ROWS)-1:0]        row_i,
  output logic [$clog2(COLUMNS)-1:0]     col_o,
  output logic [$clog2(ROWS)-1:0]        row_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0] idx_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0] off_o,
  output tmw_pkg::step_flags_t           flags_o
);
  import tmw_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int WCW   = $clog2(COLUMNS + TAB_STOP);
  localparam int RWW   = $clog2(ROWS + 1);
  localparam int AW    = $clog2(COLUMNS * ROWS);
  localparam int NSTOP = COLUMNS / TAB_STOP + 1;

  logic [WCW-1:0] wcol;
  logic [RWW-1:0] wrow;
  logic [WCW-1:0] tab_col;
  logic [CW-1:0]  idx_col;
  logic [RW-1:0]  idx_row;
  logic           written;
  logic           scroll;

  // Next tab stop: every stop is compared against the column in parallel.
  always_comb begin
    tab_col = WCW'(TAB_STOP);
    for (int k = 0; k < NSTOP; k++) begin
      if (WCW'(col_i) >= WCW'(k * TAB_STOP)) begin
        tab_col = WCW'((k + 1) * TAB_STOP);
      end
    end
  end

  always_comb begin
    wcol    = WCW'(col_i);
    wrow    = RWW'(row_i);
    idx_col = col_i;
    idx_row = row_i;
    written = 1'b0;
    case (ch)
      CH_TAB: begin
        wcol = tab_col;
      end
      CH_NL: begin
        wrow = wrow + RWW'(1);
        wcol = '0;
      end
      CH_CR: begin
        wcol = '0;
      end
      CH_BS: begin
        // Backspace at the home position leaves everything alone.
        if (col_i != '0 || row_i != '0) begin
          if (col_i == '0) begin
            wrow    = wrow - RWW'(1);
            wcol    = WCW'(COLUMNS - 1);
            idx_row = row_i - RW'(1);
            idx_col = CW'(COLUMNS - 1);
          end else begin
            wcol    = wcol - WCW'(1);
            idx_col = col_i - CW'(1);
          end
          written = 1'b1;
        end
      end
      default: begin
        written = 1'b1;
        wcol    = wcol + WCW'(1);
      end
    endcase

    if (wcol >= WCW'(COLUMNS)) begin
      wcol = wcol - WCW'(COLUMNS);
      wrow = wrow + RWW'(1);
      if (wcol >= WCW'(COLUMNS)) begin
        wcol = '0;
      end
    end

    scroll = (wrow == RWW'(ROWS));
    if (scroll) begin
      wrow = RWW'(ROWS - 1);
    end
  end

  assign col_o   = CW'(wcol);
  assign row_o   = RW'(wrow);
  assign idx_o   = written ? (AW'(idx_row) * AW'(COLUMNS) + AW'(idx_col)) : '0;
  assign off_o   = AW'(row_o) * AW'(COLUMNS) + AW'(col_o);
  assign flags_o = '{written: written, scroll: scroll};

endmodule

### bench/text_mode_terminal_writer_tb.sv
module text_mode_terminal_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmw_pkg::*;

  // Geometry of the instance under test; it is built with the package defaults.
  localparam int NCOLS = COLUMNS_DEF;
  localparam int NROWS = ROWS_DEF;
  localparam int TAB_W = TAB_STOP_DEF;

  // The limit stays above what a correct run that scrolled on every item, with
  // every result waiting out the worst stall, would need.
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int ITEMS_PER_PHASE = 340;
  localparam int NUM_PHASES = 5;
  // SETTLE_CYCLES outlasts one scroll; it is how long we watch for stray
  // results once everything has come back.
  localparam int SETTLE_CYCLES = 2200;
  localparam int HOLDOFF_AT = 250;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int MAX_REPORTS = 10;

  // One result item, in the order of the output ports.
  typedef struct packed {
    logic               written;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               scrolled;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [INDEX_W-1:0] offset;
  } cell_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  // Every input of the block starts at a known value.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CHAR_W-1:0]     in_char_code = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_cell_written;
  logic [INDEX_W-1:0]    out_cell_index;
  logic [VALUE_W-1:0]    out_cell_value;
  logic                  out_scrolled;
  logic [COL_W-1:0]      out_cursor_col;
  logic [ROW_W-1:0]      out_cursor_row;
  logic [INDEX_W-1:0]    out_cursor_offset;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = CFG_FORE_COLOR;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Our own copy of the cursor and of the color registers.
  int         term_col = 0;
  int         term_row = 0;
  logic [2:0] fg_color = FORE_COLOR_RST;
  logic       fg_bright = FORE_BRIGHT_RST;
  logic [2:0] bg_color = BACK_COLOR_RST;
  logic       bg_bright = BACK_BRIGHT_RST;

  // Characters waiting to be sent, and results still owed by the block.
  logic [CHAR_W-1:0] pending_chars[$];
  cell_result_t      cell_expect[$];

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned scroll_count = 0;
  int unsigned write_count = 0;
  int unsigned settings_used = 0;

  // Sender and receiver pacing state.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned mode_left = 0;
  int unsigned holdoff_left = 0;
  logic        holdoff_done = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;

  text_mode_terminal_writer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_written  (out_cell_written),
    .out_cell_index    (out_cell_index),
    .out_cell_value    (out_cell_value),
    .out_scrolled      (out_scrolled),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_offset (out_cursor_offset),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Moves the cursor for one character and returns the result item the block
  // must report for it. The cell store itself is never visible at the ports,
  // so only the cursor and the colors are tracked here.
  function automatic cell_result_t step_terminal(logic [CHAR_W-1:0] ch);
    cell_result_t r;
    int col;
    int row;
    logic [7:0] attr;
    r = '0;
    col = term_col;
    row = term_row;
    attr = {bg_bright, bg_color, fg_bright, fg_color};
    case (ch)
      CH_TAB: col = col - (col % TAB_W) + TAB_W;
      CH_NL: begin
        row++;
        col = 0;
      end
      CH_CR: col = 0;
      CH_BS: begin
        // At the home position a backspace has nothing to erase.
        if (col != 0 || row != 0) begin
          if (col == 0) begin
            row--;
            col = NCOLS - 1;
          end else begin
            col--;
          end
          r.written = 1'b1;
          r.index = INDEX_W'(row * NCOLS + col);
          r.value = {attr, CH_SPACE};
        end
      end
      default: begin
        // Everything else, other control bytes included, lands in a cell.
        r.written = 1'b1;
        r.index = INDEX_W'(row * NCOLS + col);
        r.value = {attr, ch};
        col++;
      end
    endcase
    if (col >= NCOLS) begin
      col -= NCOLS;
      row++;
      if (col >= NCOLS) col = 0;
    end
    // Falling off the bottom scrolls one row and keeps the cursor on the last row.
    if (row >= NROWS) begin
      row = NROWS - 1;
      r.scrolled = 1'b1;
      scroll_count++;
    end
    if (r.written) write_count++;
    r.col = COL_W'(col);
    r.row = ROW_W'(row);
    r.offset = INDEX_W'(row * NCOLS + col);
    term_col = col;
    term_row = row;
    return r;
  endfunction

  // A random character: mostly printable text, a fair share of control codes
  // and some arbitrary bytes so that every bit of the code is exercised.
  function automatic logic [CHAR_W-1:0] random_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return CHAR_W'($urandom_range(8'h20, 8'h7E));
    else if (roll < 63) return CH_NL;
    else if (roll < 70) return CH_TAB;
    else if (roll < 75) return CH_CR;
    else if (roll < 85) return CH_BS;
    else return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Fills the send queue with text. Long runs of printable characters push the cursor
  // across the right edge, long runs of backspaces walk it back over row boundaries.
  task automatic queue_text(int unsigned count);
    int unsigned k;
    int unsigned run;
    int unsigned roll;
    k = 0;
    while (k < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        run = $urandom_range(10, 100);
        repeat (run) pending_chars.push_back(CHAR_W'($urandom_range(8'h20, 8'h7E)));
        k += run;
      end else if (roll < 6) begin
        run = $urandom_range(5, 90);
        repeat (run) pending_chars.push_back(CH_BS);
        k += run;
      end else begin
        pending_chars.push_back(random_char());
        k++;
      end
    end
  endtask

  // Writes one color register and mirrors it into the predictor. The block is
  // idle whenever this runs, so the order against items does not matter.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_FORE_COLOR:  fg_color = data[2:0];
      CFG_FORE_BRIGHT: fg_bright = data[0];
      CFG_BACK_COLOR:  bg_color = data[2:0];
      CFG_BACK_BRIGHT: bg_bright = data[0];
      default: ;
    endcase
  endtask

  task automatic set_colors(logic [2:0] fc, logic fb, logic [2:0] bc, logic bb);
    write_reg(CFG_FORE_COLOR, fc);
    write_reg(CFG_FORE_BRIGHT, CFG_DATA_W'(fb));
    write_reg(CFG_BACK_COLOR, bc);
    write_reg(CFG_BACK_BRIGHT, CFG_DATA_W'(bb));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Returns once every queued item has been taken and answered and the block
  // has settled, before the colors change.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_chars.size() != 0 || in_valid || cell_expect.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic flag_mismatch(string why, cell_result_t want, cell_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, why);
      $display("  expected: wr=%0b idx=%0d val=%h scr=%0b col=%0d row=%0d off=%0d",
               want.written, want.index, want.value, want.scrolled,
               want.col, want.row, want.offset);
      $display("  actual:   wr=%0b idx=%0d val=%h scr=%0b col=%0d row=%0d off=%0d",
               got.written, got.index, got.value, got.scrolled,
               got.col, got.row, got.offset);
    end
  endtask

  // Sender. It offers items in bursts of random length separated by random
  // gaps; some bursts follow each other with no gap at all. Once an item is
  // up it stays up, unchanged, until the block takes it, and the predictor
  // runs at the very edge that takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        cell_expect.push_back(step_terminal(in_char_code));
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_chars.size() != 0) begin
        in_valid <= 1'b1;
        in_char_code <= pending_chars.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Every result taken is compared with the oldest expectation.
  // The stall line follows a pattern that switches between free flow, light
  // and heavy random stalling and a strict toggle. Once in the run it holds
  // off for a long stretch while the sender keeps going, so the block's output
  // register fills and the block has to stall its input.
  always @(posedge clk) begin
    cell_result_t got;
    cell_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_cell_written, out_cell_index, out_cell_value, out_scrolled,
                out_cursor_col, out_cursor_row, out_cursor_offset};
        results_checked++;
        if (cell_expect.size() == 0) begin
          flag_mismatch("result item arrived with nothing expected", '0, got);
        end else begin
          want = cell_expect.pop_front();
          if (got !== want) flag_mismatch("result item differs", want, got);
        end
      end

      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (!holdoff_done && results_checked >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Watchdog against a block that stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d results still owed.",
               cycle_count, cell_expect.size());
      $display("text_mode_terminal_writer: mismatch");
      $finish;
    end
  end

  initial begin
    // Reset is held first, then released. The block then clears its store, stalling
    // its input meanwhile, and the first items simply wait for that.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening in the reset colors. It starts with a backspace at the
    // home position, writes the lowest and highest codes and an escape byte
    // as plain characters, erases one of them, and returns the carriage.
    // Ten tabs then run the cursor past the last column into the next row,
    // a backspace there wraps back to the end of the top row, and a character
    // written in the last column wraps forward again. A newline, a space, a
    // high byte, one more tab and the delete byte close the sequence.
    pending_chars = '{CH_BS, 8'h00, 8'hFF, 8'h1B, CH_BS, CH_CR,
                      CH_TAB, CH_TAB, CH_TAB, CH_TAB, CH_TAB,
                      CH_TAB, CH_TAB, CH_TAB, CH_TAB, CH_TAB,
                      CH_BS, 8'h7E, CH_NL, CH_SPACE, 8'h80, CH_TAB, 8'h7F};
    wait_drained();

    // Random text under several color settings: all bits clear, all bits set,
    // the reset colors and random ones. Scrolling comes from the newlines and
    // long lines in the text.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_colors(3'd0, 1'b0, 3'd0, 1'b0);
        1: set_colors(3'd7, 1'b1, 3'd7, 1'b1);
        3: set_colors(FORE_COLOR_RST, FORE_BRIGHT_RST, BACK_COLOR_RST, BACK_BRIGHT_RST);
        default: set_colors(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                            3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      endcase
      queue_text(ITEMS_PER_PHASE);
      wait_drained();
    end

    // Anything that shows up now was never asked for.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d characters under %0d color settings; %0d result items checked.",
             items_sent, settings_used, results_checked);
    $display("Predicted %0d cell writes and %0d scrolls; %0d mismatches seen.",
             write_count, scroll_count, mismatches);
    if (mismatches == 0) begin
      $display("text_mode_terminal_writer: match");
    end else begin
      $display("text_mode_terminal_writer: mismatch");
    end
    $finish;
  end

endmodule
